[design/bam_pkg.sv]
package bam_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int MaxHeight   = 1024;
  localparam int BlockSize   = 3;
  localparam int ChanCount   = 4;
  localparam int ChW         = 8;
  localparam int SumW        = 12;
  localparam int CoordW      = 10;
  localparam int CfgW        = 11;
  localparam int EffW        = 13;
  localparam int RowW        = 10;
  localparam int ApbAddrW    = 3;
  localparam int ApbDataW    = 32;

  // register indexes
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // 1/9 as 3641 / 2^15; exact floor for every 12-bit sum
  localparam int RecipNine  = 3641;
  localparam int RecipShift = 15;

  typedef logic [ChanCount-1:0][SumW-1:0] bam_sums_t;
  typedef logic [ChanCount-1:0][ChW-1:0]  bam_pix_t;

  // item handed from position tracking to the accumulator
  typedef struct packed {
    logic              acc;
    logic              fresh;
    logic              emit;
    bam_pix_t          px;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } bam_req_t;

  // run of results: one pixel, or a whole block from its sums
  typedef struct packed {
    logic              blk;
    bam_sums_t         val;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } bam_job_t;

  function automatic logic [ChW-1:0] div9(input logic [SumW-1:0] x);
    logic [SumW+13:0] prod;
    prod = (SumW+14)'(x) * (SumW+14)'(RecipNine);
    return prod[RecipShift +: ChW];
  endfunction

endpackage

[design/bam_if.sv]
interface bam_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_alpha;
  logic       frame_start;

  modport source(output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                 frame_start, input ready);
  modport sink(input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
               frame_start, output ready);
endinterface

interface bam_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_row;
  logic [9:0] out_column;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       last_of_run;

  modport source(output valid, out_row, out_column, out_red, out_green, out_blue,
                 out_alpha, last_of_run, input ready);
  modport sink(input valid, out_row, out_column, out_red, out_green, out_blue,
               out_alpha, last_of_run, output ready);
endinterface

[design/bam_accum.sv]
module bam_accum #(
  parameter int  MAX_WIDTH = bam_pkg::MaxWidthDef,
  localparam int SumDepth  = MAX_WIDTH / bam_pkg::BlockSize,
  localparam int IdxW      = (SumDepth > 1) ? $clog2(SumDepth) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  bam_pkg::bam_req_t req,
  input  logic [IdxW-1:0]   req_idx,
  output logic              job_valid,
  input  logic              job_ready,
  output bam_pkg::bam_job_t job
);

  bam_pkg::bam_sums_t sum_mem [SumDepth];

  bam_pkg::bam_sums_t rd_q_r;
  bam_pkg::bam_sums_t fwd_q_r;
  logic               fwd_hit_r;
  logic               s1_v_r;
  bam_pkg::bam_req_t  s1_r;
  logic [IdxW-1:0]    s1_idx_r;

  bam_pkg::bam_sums_t base;
  bam_pkg::bam_sums_t sum_new;
  logic               job_need;
  logic               s1_fire;
  logic               req_take;

  always_comb begin
    priority if (s1_r.fresh) begin
      base = '0;
    end else if (fwd_hit_r) begin
      base = fwd_q_r;
    end else begin
      base = rd_q_r;
    end
    for (int i = 0; i < bam_pkg::ChanCount; i++) begin
      sum_new[i] = base[i] + bam_pkg::SumW'(s1_r.px[i]);
    end
  end

  assign job_need  = s1_r.emit || !s1_r.acc;
  assign s1_fire   = s1_v_r && (!job_need || job_ready);
  assign req_ready = !s1_v_r || s1_fire;
  assign req_take  = req_valid && req_ready;
  assign job_valid = s1_v_r && job_need;

  always_comb begin
    job.blk = s1_r.emit;
    job.row = s1_r.row;
    job.col = s1_r.col;
    for (int i = 0; i < bam_pkg::ChanCount; i++) begin
      job.val[i] = s1_r.acc ? sum_new[i] : bam_pkg::SumW'(s1_r.px[i]);
    end
  end

  // read at accept, write back as the item leaves
  always_ff @(posedge clk) begin
    if (req_take && req.acc) begin
      rd_q_r <= sum_mem[req_idx];
    end
    if (s1_fire && s1_r.acc) begin
      sum_mem[s1_idx_r] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (req_take) begin
        s1_v_r    <= 1'b1;
        // same-edge write is not seen by the read: forward it
        fwd_hit_r <= s1_fire && s1_r.acc && (s1_idx_r == req_idx);
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_r     <= req;
      s1_idx_r <= req_idx;
      fwd_q_r  <= sum_new;
    end
  end

endmodule

[design/bam_emit.sv]
module bam_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  bam_pkg::bam_job_t job,
  bam_out_if.source         out_ch
);

  logic                          slot_v_r;
  bam_pkg::bam_job_t             slot_r;
  logic                          cur_v_r;
  logic                          cur_blk_r;
  bam_pkg::bam_pix_t             cur_val_r;
  logic [bam_pkg::CoordW-1:0]    cur_row_r;
  logic [bam_pkg::CoordW-1:0]    cur_col_r;
  logic [1:0]                    dr_r;
  logic [1:0]                    dc_r;

  logic                          cur_last;
  logic                          out_take;
  logic                          cur_free;
  logic                          slot_mv;
  bam_pkg::bam_pix_t             load_val;

  assign cur_last  = !cur_blk_r || (dr_r == 2'(bam_pkg::BlockSize - 1) &&
                                    dc_r == 2'(bam_pkg::BlockSize - 1));
  assign out_take  = cur_v_r && out_ch.ready;
  assign cur_free  = !cur_v_r || (out_ch.ready && cur_last);
  assign slot_mv   = slot_v_r && cur_free;
  assign job_ready = !slot_v_r || slot_mv;

  always_comb begin
    for (int i = 0; i < bam_pkg::ChanCount; i++) begin
      load_val[i] = slot_r.blk ? bam_pkg::div9(slot_r.val[i])
                               : slot_r.val[i][bam_pkg::ChW-1:0];
    end
  end

  assign out_ch.valid       = cur_v_r;
  assign out_ch.out_row     = cur_row_r + bam_pkg::CoordW'(dr_r);
  assign out_ch.out_column  = cur_col_r + bam_pkg::CoordW'(dc_r);
  assign out_ch.out_red     = cur_val_r[0];
  assign out_ch.out_green   = cur_val_r[1];
  assign out_ch.out_blue    = cur_val_r[2];
  assign out_ch.out_alpha   = cur_val_r[3];
  assign out_ch.last_of_run = cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
      cur_v_r  <= 1'b0;
      dr_r     <= '0;
      dc_r     <= '0;
    end else begin
      if (job_valid && job_ready) begin
        slot_v_r <= 1'b1;
      end else if (slot_mv) begin
        slot_v_r <= 1'b0;
      end
      if (slot_mv) begin
        cur_v_r <= 1'b1;
        dr_r    <= '0;
        dc_r    <= '0;
      end else if (cur_free) begin
        cur_v_r <= 1'b0;
      end else if (out_take) begin
        // walk the block in raster order
        if (dc_r == 2'(bam_pkg::BlockSize - 1)) begin
          dc_r <= '0;
          dr_r <= dr_r + 2'd1;
        end else begin
          dc_r <= dc_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      slot_r <= job;
    end
    if (slot_mv) begin
      cur_blk_r <= slot_r.blk;
      cur_val_r <= load_val;
      cur_row_r <= slot_r.row;
      cur_col_r <= slot_r.col;
    end
  end

endmodule

[design/block_average_mosaic.sv]
// 3x3 block-average mosaic on a raster stream of RGBA pixels.
// in_ch carries one pixel per word; frame_start marks row 0, column 0.
// out_ch carries one pixel per word with its row and column; last_of_run
// closes the results caused by one input word.
// Pixels inside a full 3x3 block give nothing until the block's bottom-right
// pixel arrives, which gives the block's nine averaged pixels in raster order.
// Pixels right of the last full block or below the last full band pass
// through, one result each.
// An accepted word passes the accumulator stage, the emit slot and the emit
// output register before its first result is offered. Throughput: one input
// word per cycle while each gives at most one result and out_ch is ready;
// out_ch moves one word per cycle, so a completing pixel can hold the input back while its nine words go out.
// The sums live in one single-port-write memory, one entry per block column,
// read at accept and written back as the item leaves the accumulator stage, with forwarding.
// Reset clears position and handshake state and sets both frame registers to
// 512; the sum memory needs no clearing. A stalled out_ch holds its word and
// backs up through the pipeline to in_ch.ready.
// Registers (APB): 0x0 frame_width, 0x4 frame_height, 11 bits each.
module block_average_mosaic #(
  parameter int MAX_WIDTH = bam_pkg::MaxWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bam_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bam_pkg::ApbDataW-1:0]  pwdata,
  output logic [bam_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  bam_in_if.sink                        in_ch,
  bam_out_if.source                     out_ch
);

  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int SumDepth = MAX_WIDTH / bam_pkg::BlockSize;
  localparam int IdxW     = (SumDepth > 1) ? $clog2(SumDepth) : 1;
  localparam int EffW     = bam_pkg::EffW;
  localparam logic [EffW-1:0] MaxW = EffW'(MAX_WIDTH);
  localparam logic [EffW-1:0] MaxH = EffW'(bam_pkg::MaxHeight);
  localparam logic [EffW-1:0] Blk  = EffW'(bam_pkg::BlockSize);

  logic [bam_pkg::CfgW-1:0] width_r;
  logic [bam_pkg::CfgW-1:0] height_r;
  logic [ColW-1:0]          col_r;
  logic [ColW-1:0]          col_nxt;
  logic [ColW-1:0]          bidx_r;
  logic [ColW-1:0]          bidx_nxt;
  logic [1:0]               cmod_r;
  logic [1:0]               cmod_nxt;
  logic [bam_pkg::RowW-1:0] row_r;
  logic [bam_pkg::RowW-1:0] row_nxt;
  logic [1:0]               rmod_r;
  logic [1:0]               rmod_nxt;

  logic [EffW-1:0]          w_eff;
  logic [EffW-1:0]          h_eff;
  logic [ColW-1:0]          c;
  logic [ColW-1:0]          bidx;
  logic [1:0]               cmod;
  logic [bam_pkg::RowW-1:0] r;
  logic [1:0]               rmod;
  logic [EffW-1:0]          c1;
  logic [EffW-1:0]          r1;
  logic [EffW-1:0]          col_blk;
  logic [EffW-1:0]          row_blk;

  logic                     req_ready;
  logic                     in_take;
  bam_pkg::bam_req_t        req;
  logic                     job_valid;
  logic                     job_ready;
  bam_pkg::bam_job_t        job;
  logic                     cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bam_pkg::RegFrameHeight) ?
                  bam_pkg::ApbDataW'(height_r) : bam_pkg::ApbDataW'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bam_pkg::CfgW'(512);
      height_r <= bam_pkg::CfgW'(512);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bam_pkg::RegFrameWidth:  width_r  <= pwdata[bam_pkg::CfgW-1:0];
        bam_pkg::RegFrameHeight: height_r <= pwdata[bam_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (width_r == '0) begin
      w_eff = EffW'(1);
    end else if (EffW'(width_r) > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = EffW'(width_r);
    end
    priority if (height_r == '0) begin
      h_eff = EffW'(1);
    end else if (EffW'(height_r) > MaxH) begin
      h_eff = MaxH;
    end else begin
      h_eff = EffW'(height_r);
    end
  end

  // position of the word on in_ch and the position after it
  always_comb begin
    c    = in_ch.frame_start ? '0 : col_r;
    bidx = in_ch.frame_start ? '0 : bidx_r;
    cmod = in_ch.frame_start ? '0 : cmod_r;
    r    = in_ch.frame_start ? '0 : row_r;
    rmod = in_ch.frame_start ? '0 : rmod_r;

    col_blk = EffW'(c) - EffW'(cmod);
    row_blk = EffW'(r) - EffW'(rmod);

    req.acc   = (col_blk + Blk <= w_eff) && (row_blk + Blk <= h_eff);
    req.fresh = (cmod == 2'd0) && (rmod == 2'd0);
    req.emit  = req.acc && (cmod == 2'(bam_pkg::BlockSize - 1)) &&
                (rmod == 2'(bam_pkg::BlockSize - 1));
    req.px    = {in_ch.pixel_alpha, in_ch.pixel_blue, in_ch.pixel_green,
                 in_ch.pixel_red};
    req.row   = req.emit ? bam_pkg::CoordW'(r - bam_pkg::RowW'(2))
                         : bam_pkg::CoordW'(r);
    req.col   = req.emit ? bam_pkg::CoordW'(c - ColW'(2)) : bam_pkg::CoordW'(c);

    c1 = EffW'(c) + EffW'(1);
    r1 = EffW'(r) + EffW'(1);
    if (c1 >= w_eff) begin
      col_nxt  = '0;
      bidx_nxt = '0;
      cmod_nxt = '0;
      if (r1 >= h_eff) begin
        row_nxt  = '0;
        rmod_nxt = '0;
      end else begin
        row_nxt  = r1[bam_pkg::RowW-1:0];
        rmod_nxt = (rmod == 2'(bam_pkg::BlockSize - 1)) ? 2'd0 : rmod + 2'd1;
      end
    end else begin
      col_nxt = c1[ColW-1:0];
      if (cmod == 2'(bam_pkg::BlockSize - 1)) begin
        cmod_nxt = '0;
        bidx_nxt = bidx + ColW'(1);
      end else begin
        cmod_nxt = cmod + 2'd1;
        bidx_nxt = bidx;
      end
      // height shrunk under the current row: wrap
      if (EffW'(r) >= h_eff) begin
        row_nxt  = '0;
        rmod_nxt = '0;
      end else begin
        row_nxt  = r;
        rmod_nxt = rmod;
      end
    end
  end

  assign in_ch.ready = req_ready;
  assign in_take     = in_ch.valid && req_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      bidx_r <= '0;
      cmod_r <= '0;
      row_r  <= '0;
      rmod_r <= '0;
    end else if (in_take) begin
      col_r  <= col_nxt;
      bidx_r <= bidx_nxt;
      cmod_r <= cmod_nxt;
      row_r  <= row_nxt;
      rmod_r <= rmod_nxt;
    end
  end

  bam_accum #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (req_ready),
    .req       (req),
    .req_idx   (bidx[IdxW-1:0]),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  bam_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_ch    (out_ch)
  );

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmod_r != 2'd3) && (rmod_r != 2'd3))
    else $error("block phase counter out of range");

  a_idx_in_mem: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && req.acc) |-> (32'(bidx) < 32'(SumDepth)))
    else $error("sum index beyond memory depth");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> out_ch.valid)
    else $error("block run broken before its last word");

  a_emit_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && req.emit) |-> (req.acc && !req.fresh))
    else $error("block completion outside a full block");

endmodule

[tb/sv/block_average_mosaic_tb.sv]
`timescale 1ns / 100ps

typedef struct packed {
  bam_pkg::bam_pix_t chans;   // [0] red, [1] green, [2] blue, [3] alpha
  logic              start;
} pixel_t;

typedef struct packed {
  logic [bam_pkg::CoordW-1:0] row;
  logic [bam_pkg::CoordW-1:0] col;
  bam_pkg::bam_pix_t          chans;
  logic                       last;
} mosaic_px_t;

class mosaic_scoreboard;
  logic [bam_pkg::CfgW-1:0] width_reg;
  logic [bam_pkg::CfgW-1:0] height_reg;
  bam_pkg::bam_sums_t       col_sums [bam_pkg::MaxWidthDef/bam_pkg::BlockSize + 1];
  int unsigned              col_pos;
  int unsigned              row_pos;
  mosaic_px_t               awaited_px [$];
  string                    chan_name [4];
  int unsigned              fails;
  int unsigned              pixels_in;
  int unsigned              results_in;
  int unsigned              blocks_done;
  int unsigned              passed_px;

  function new();
    width_reg   = 512;
    height_reg  = 512;
    col_pos     = 0;
    row_pos     = 0;
    chan_name   = '{"red", "green", "blue", "alpha"};
    fails       = 0;
    pixels_in   = 0;
    results_in  = 0;
    blocks_done = 0;
    passed_px   = 0;
  endfunction

  function void set_reg(logic idx, logic [bam_pkg::CfgW-1:0] value);
    if (idx == bam_pkg::RegFrameWidth) width_reg = value;
    else height_reg = value;
  endfunction

  function int unsigned clamp_size(logic [bam_pkg::CfgW-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function int unsigned pending();
    return awaited_px.size();
  endfunction

  // Work out the words one accepted pixel causes and queue them.
  function void note_pixel(pixel_t p);
    int unsigned w, h, full_w, full_h, r, c, idx, ch, dr, dc;
    bit fresh;
    bam_pkg::bam_pix_t avg;
    mosaic_px_t res;
    w = clamp_size(width_reg, bam_pkg::MaxWidthDef);
    h = clamp_size(height_reg, bam_pkg::MaxHeight);
    full_w = (w / bam_pkg::BlockSize) * bam_pkg::BlockSize;
    full_h = (h / bam_pkg::BlockSize) * bam_pkg::BlockSize;
    pixels_in++;
    if (p.start) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (r < full_h && c < full_w) begin
      idx = c / bam_pkg::BlockSize;
      fresh = (r % bam_pkg::BlockSize == 0) && (c % bam_pkg::BlockSize == 0);
      for (ch = 0; ch < bam_pkg::ChanCount; ch++)
        col_sums[idx][ch] = (fresh ? 12'd0 : col_sums[idx][ch]) + 12'(p.chans[ch]);
      // bottom-right pixel closes the block: emit all nine in raster order
      if (r % bam_pkg::BlockSize == 2 && c % bam_pkg::BlockSize == 2) begin
        for (ch = 0; ch < bam_pkg::ChanCount; ch++)
          avg[ch] = 8'(int'(col_sums[idx][ch]) / (bam_pkg::BlockSize * bam_pkg::BlockSize));
        for (dr = 0; dr < bam_pkg::BlockSize; dr++)
          for (dc = 0; dc < bam_pkg::BlockSize; dc++) begin
            res.row   = 10'(r - 2 + dr);
            res.col   = 10'(c - 2 + dc);
            res.chans = avg;
            res.last  = (dr == 2) && (dc == 2);
            awaited_px.push_back(res);
          end
        blocks_done++;
      end
    end else begin
      res.row   = 10'(r);
      res.col   = 10'(c);
      res.chans = p.chans;
      res.last  = 1'b1;
      awaited_px.push_back(res);
      passed_px++;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end else if (r >= h) begin
      r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task report(string msg);
    fails++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task match_field(string name, logic [9:0] got, logic [9:0] want, mosaic_px_t at);
    if (got !== want)
      report($sformatf("row %0d column %0d %s: got %0d, expected %0d",
                       at.row, at.col, name, got, want));
  endtask

  task check_result(mosaic_px_t got);
    mosaic_px_t want;
    int unsigned ch;
    results_in++;
    if (awaited_px.size() == 0) begin
      report($sformatf("unexpected word at row %0d column %0d", got.row, got.col));
      return;
    end
    want = awaited_px.pop_front();
    match_field("row", got.row, want.row, want);
    match_field("column", got.col, want.col, want);
    for (ch = 0; ch < bam_pkg::ChanCount; ch++)
      match_field(chan_name[ch], 10'(got.chans[ch]), 10'(want.chans[ch]), want);
    match_field("last_of_run", 10'(got.last), 10'(want.last), want);
  endtask
endclass

module block_average_mosaic_tb;

  localparam int RandomItems   = 195;
  localparam int SettleGap     = 16;
  localparam int EndGap        = 20;
  localparam int LongHold      = 300;
  localparam int HoldAt        = 30;
  localparam int PauseAt       = 140;
  localparam int WatchdogLimit = 4000;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bam_pkg::ApbAddrW-1:0] paddr;
  logic [bam_pkg::ApbDataW-1:0] pwdata;
  logic [bam_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  bam_in_if  in_ch ();
  bam_out_if out_ch ();

  block_average_mosaic DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  mosaic_scoreboard sb;
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 64;
  int unsigned hold_asked    = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned reg_writes    = 0;
  int unsigned frames_sent   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken   <= hold_asked;
      hold_left    <= LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_in
    pixel_t p;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.chans = {in_ch.pixel_alpha, in_ch.pixel_blue, in_ch.pixel_green, in_ch.pixel_red};
      p.start = in_ch.frame_start;
      sb.note_pixel(p);
    end
  end

  always @(posedge clk) begin : watch_out
    mosaic_px_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.row   = out_ch.out_row;
      got.col   = out_ch.out_column;
      got.chans = {out_ch.out_alpha, out_ch.out_blue, out_ch.out_green, out_ch.out_red};
      got.last  = out_ch.last_of_run;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t make_pixel(logic start);
    pixel_t p;
    int ch;
    for (ch = 0; ch < bam_pkg::ChanCount; ch++) p.chans[ch] = rand_byte();
    p.start = start;
    return p;
  endfunction

  // Write a frame register, read it back, and mirror it in the predictor.
  task automatic write_reg(input logic idx, input logic [bam_pkg::CfgW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bam_pkg::ApbAddrW'({idx, 2'b00});
    pwdata  <= bam_pkg::ApbDataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[bam_pkg::CfgW-1:0] !== value)
      sb.report($sformatf("register %0d read back %0d, written %0d", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    reg_writes++;
  endtask

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_red   <= p.chans[0];
    in_ch.pixel_green <= p.chans[1];
    in_ch.pixel_blue  <= p.chans[2];
    in_ch.pixel_alpha <= p.chans[3];
    in_ch.frame_start <= p.start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, let the last word reach the predictor, wait for every queued
  // word, then let the pipeline empty.
  task automatic settle(input int unsigned gap);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  initial begin
    pixel_t p;
    int unsigned k, fw, fh, npix, random_sent, restart_at;
    bit need_start, start_first;

    sb                = new();
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_red   = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue  = '0;
    in_ch.pixel_alpha = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame: one block of full-scale pixels, then a second frame
    // by wrap alone with mixed extremes to check truncation.
    write_reg(bam_pkg::RegFrameWidth, 11'd3);
    write_reg(bam_pkg::RegFrameHeight, 11'd3);
    for (k = 0; k < 9; k++) begin
      p.chans = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      p.start = (k == 0);
      send_pixel(p);
    end
    frames_sent++;
    for (k = 0; k < 9; k++) begin
      p.chans[0] = (k % 2 == 0) ? 8'hFF : 8'h00;
      p.chans[1] = ~p.chans[0];
      p.chans[2] = 8'(k * 28);
      p.chans[3] = (k == 4) ? 8'hFF : 8'h00;
      p.start    = 1'b0;
      send_pixel(p);
    end
    frames_sent++;

    // Narrow frame, all pass-through; shrink width and height mid-frame so the
    // position wraps on the next advance, height 0 taken as one row.
    settle(SettleGap);
    write_reg(bam_pkg::RegFrameWidth, 11'd2);
    write_reg(bam_pkg::RegFrameHeight, 11'd5);
    for (k = 0; k < 3; k++) send_pixel(make_pixel(k == 0));
    settle(SettleGap);
    write_reg(bam_pkg::RegFrameWidth, 11'd1);
    send_pixel(make_pixel(1'b0));
    settle(SettleGap);
    write_reg(bam_pkg::RegFrameWidth, 11'd2);
    write_reg(bam_pkg::RegFrameHeight, 11'd0);
    for (k = 0; k < 2; k++) send_pixel(make_pixel(1'b0));
    frames_sent++;

    // Both registers above range: clamped to the largest frame.
    settle(SettleGap);
    write_reg(bam_pkg::RegFrameWidth, 11'd2047);
    write_reg(bam_pkg::RegFrameHeight, 11'd2047);
    for (k = 0; k < 2; k++) send_pixel(make_pixel(k == 0));
    frames_sent++;

    random_sent = 0;
    need_start  = 1'b1;
    fw          = 0;
    while (random_sent < RandomItems) begin
      if (fw == 0 || $urandom_range(1) == 0) begin
        settle(SettleGap);
        if ($urandom_range(7) == 0) begin
          fw = $urandom_range(1, 2);
          fh = $urandom_range(1, 9);
        end else if ($urandom_range(7) == 0) begin
          fw = $urandom_range(3, 12);
          fh = $urandom_range(1, 2);
        end else begin
          fw = $urandom_range(3, 12);
          fh = $urandom_range(3, 8);
        end
        write_reg(bam_pkg::RegFrameWidth, 11'(fw));
        write_reg(bam_pkg::RegFrameHeight, 11'(fh));
        need_start = 1'b1;
      end
      npix = fw * fh;
      // noise: cut the frame short, or restart it part way through
      if ($urandom_range(9) == 0) npix = $urandom_range(1, npix);
      restart_at  = ($urandom_range(9) == 0 && npix > 1) ? $urandom_range(1, npix - 1) : npix;
      start_first = need_start || ($urandom_range(3) != 0);
      need_start  = 1'b0;
      for (k = 0; k < npix && random_sent < RandomItems; k++) begin
        if (random_sent < RandomItems / 3) begin
          send_idle_pct = 11;
          recv_idle_pct = 64;
        end else if (random_sent < 2 * RandomItems / 3) begin
          send_idle_pct = 64;
          recv_idle_pct = 11;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_pixel(make_pixel((k == 0 && start_first) || k == restart_at));
        random_sent++;
        if (random_sent == HoldAt) hold_asked <= hold_asked + 1;
        if (random_sent == PauseAt) settle(1);
      end
      frames_sent++;
    end

    settle(EndGap);
    $display("Ran %0d frames across %0d register writes: %0d pixels in, %0d words out",
             frames_sent, reg_writes, sb.pixels_in, sb.results_in);
    $display("%0d blocks averaged, %0d pixels passed through, with long output stall and drain",
             sb.blocks_done, sb.passed_px);
    if (sb.fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/bam_pkg.sv
design/bam_if.sv
design/bam_accum.sv
design/bam_emit.sv
design/block_average_mosaic.sv
tb/sv/block_average_mosaic_tb.sv
